// File: sv/mrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

  // Port widths of the item fields
  localparam int ACTION_W    = 3;
  localparam int THREAD_ID_W = 6;
  localparam int PRIO_W      = 8;
  localparam int LEVEL_W     = 2;
  localparam int TOTAL_W     = 7;

  // Default sizing
  localparam int DEF_MAX_THREADS = 64;
  localparam int DEF_NUM_BUCKETS = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 3'd0,
    ACT_PICK    = 3'd1,
    ACT_STEAL   = 3'd2,
    ACT_PREEMPT = 3'd3,
    ACT_PEEK    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

// File: sv/multilevel_run_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// req       req_valid/req_ready  action, thread_id, priority_req, level
// rsp       rsp_valid/rsp_ready  result_thread, found, status, preempt, queued_total
//
// Each request has a read cycle, which reads the queued flag and link memories,
// and an update cycle for the links, bucket registers and the response register.
// After reset the queued flag memory is cleared one entry per cycle, and
// req_ready stays low until every entry has been cleared.
// A response waiting on rsp_ready holds the update of the next request; the
// next request is still taken into its read cycle.

module multilevel_run_queue #(
  parameter int MAX_THREADS = mrq_pkg::DEF_MAX_THREADS,
  parameter int NUM_BUCKETS = mrq_pkg::DEF_NUM_BUCKETS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire logic [mrq_pkg::ACTION_W-1:0]    action,
  input  wire logic [mrq_pkg::THREAD_ID_W-1:0] thread_id,
  input  wire logic [mrq_pkg::PRIO_W-1:0]      priority_req,
  input  wire logic [mrq_pkg::LEVEL_W-1:0]     level,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output logic [mrq_pkg::THREAD_ID_W-1:0]      result_thread,
  output logic                                 found,
  output logic                                 status,
  output logic                                 preempt,
  output logic [mrq_pkg::TOTAL_W-1:0]          queued_total
);

  import mrq_pkg::*;

  localparam int TID_W  = $clog2(MAX_THREADS);
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int PROD_W = PRIO_W + BKT_W + 1;

  // Storage
  logic [TID_W-1:0] next_mem [MAX_THREADS];
  logic [TID_W-1:0] prev_mem [MAX_THREADS];
  logic             flag_mem [MAX_THREADS];

  logic [TID_W-1:0] bucket_head   [NUM_BUCKETS];
  logic [TID_W-1:0] bucket_tail   [NUM_BUCKETS];
  logic [CNT_W-1:0] bucket_length [NUM_BUCKETS];
  logic [CNT_W-1:0] total_count;

  state_t state, state_next;
  logic [TID_W-1:0] clr_cnt;

  // Request registers
  logic [ACTION_W-1:0] act_q;
  logic [TID_W-1:0]    tid_q;
  logic                tid_ok_q;
  logic [BKT_W-1:0]    sel_b_q;
  logic                sel_ok_q;
  logic                preempt_q;
  logic                flag_rd;
  logic [TID_W-1:0]    next_rd;
  logic [TID_W-1:0]    prev_rd;

  logic req_fire;
  logic exec_fire;

  // Request decode
  logic [TID_W+THREAD_ID_W-1:0] tid_wide;
  logic [TID_W-1:0]             tid_idx;
  logic                         tid_ok;
  logic [PROD_W-1:0]            prio_prod;
  logic [BKT_W-1:0]             enq_b;
  logic [BKT_W+LEVEL_W-1:0]     level_wide;
  logic [BKT_W-1:0]             level_idx;
  logic                         level_ok;
  logic [NUM_BUCKETS-1:0]       nonempty;
  logic [BKT_W-1:0]             hi_b, lo_b, sel_b;
  logic                         any_ne, above_ne, sel_ok;

  assign tid_wide   = (TID_W + THREAD_ID_W)'(thread_id);
  assign tid_idx    = tid_wide[TID_W-1:0];
  assign tid_ok     = 32'(thread_id) < MAX_THREADS;
  assign prio_prod  = PROD_W'(priority_req) * PROD_W'(NUM_BUCKETS);
  assign enq_b      = prio_prod[PRIO_W +: BKT_W];
  assign level_wide = (BKT_W + LEVEL_W)'(level);
  assign level_idx  = level_wide[BKT_W-1:0];
  assign level_ok   = 32'(level) < NUM_BUCKETS;

  always_comb begin
    hi_b     = '0;
    lo_b     = '0;
    any_ne   = 1'b0;
    above_ne = 1'b0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      nonempty[b] = bucket_length[b] != '0;
    end
    // hi_b ends on the highest non-empty bucket
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      if (nonempty[b]) begin
        hi_b   = BKT_W'(b);
        any_ne = 1'b1;
      end
      if (nonempty[b] && b > int'(enq_b)) begin
        above_ne = 1'b1;
      end
    end
    for (int b = NUM_BUCKETS - 1; b >= 0; b--) begin
      if (nonempty[b]) begin
        lo_b = BKT_W'(b);
      end
    end
    case (action)
      ACT_ENQUEUE: begin
        sel_b  = enq_b;
        sel_ok = 1'b1;
      end
      ACT_PICK: begin
        sel_b  = hi_b;
        sel_ok = any_ne;
      end
      ACT_STEAL: begin
        sel_b  = lo_b;
        sel_ok = any_ne;
      end
      ACT_PEEK: begin
        sel_b  = level_idx;
        sel_ok = level_ok && nonempty[level_idx];
      end
      default: begin
        sel_b  = '0;
        sel_ok = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    exec_fire  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == TID_W'(MAX_THREADS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold while the previous response waits
        if (!rsp_valid || rsp_ready) begin
          exec_fire  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign req_fire = req_valid && req_ready;

  // Read cycle: latch the request and read the flag and links
  always_ff @(posedge clk) begin
    if (req_fire) begin
      act_q     <= action;
      tid_q     <= tid_idx;
      tid_ok_q  <= tid_ok;
      sel_b_q   <= sel_b;
      sel_ok_q  <= sel_ok;
      preempt_q <= above_ne;
      flag_rd   <= flag_mem[tid_idx];
      next_rd   <= next_mem[bucket_head[sel_b]];
      prev_rd   <= prev_mem[bucket_tail[sel_b]];
    end
  end

  // Update cycle
  logic [TID_W-1:0] sel_head, sel_tail;
  logic [CNT_W-1:0] sel_len;
  logic             head_we, tail_we, len_we, flag_we, link_we;
  logic [TID_W-1:0] head_next, tail_next;
  logic [CNT_W-1:0] len_next, total_next;
  logic [TID_W-1:0] flag_addr;
  logic             flag_data;
  logic [TID_W-1:0] r_thread;
  logic             r_found, r_status, r_preempt;

  assign sel_head = bucket_head[sel_b_q];
  assign sel_tail = bucket_tail[sel_b_q];
  assign sel_len  = bucket_length[sel_b_q];

  always_comb begin
    head_we    = 1'b0;
    tail_we    = 1'b0;
    len_we     = 1'b0;
    flag_we    = 1'b0;
    link_we    = 1'b0;
    head_next  = tid_q;
    tail_next  = tid_q;
    len_next   = sel_len;
    total_next = total_count;
    flag_addr  = tid_q;
    flag_data  = 1'b0;
    r_thread   = '0;
    r_found    = 1'b0;
    r_status   = 1'b0;
    r_preempt  = 1'b0;
    case (act_q)
      ACT_ENQUEUE: begin
        if (!tid_ok_q || flag_rd) begin
          r_status = 1'b1;
        end else begin
          link_we    = sel_len != '0;
          head_we    = sel_len == '0;
          tail_we    = 1'b1;
          len_we     = 1'b1;
          len_next   = sel_len + 1'b1;
          flag_we    = 1'b1;
          flag_data  = 1'b1;
          total_next = total_count + 1'b1;
        end
      end
      ACT_PICK: begin
        if (sel_ok_q) begin
          r_thread   = sel_head;
          r_found    = 1'b1;
          head_we    = sel_len != CNT_W'(1);
          head_next  = next_rd;
          len_we     = 1'b1;
          len_next   = sel_len - 1'b1;
          flag_we    = 1'b1;
          flag_addr  = sel_head;
          total_next = total_count - 1'b1;
        end
      end
      ACT_STEAL: begin
        if (sel_ok_q) begin
          r_thread   = sel_tail;
          r_found    = 1'b1;
          tail_we    = sel_len != CNT_W'(1);
          tail_next  = prev_rd;
          len_we     = 1'b1;
          len_next   = sel_len - 1'b1;
          flag_we    = 1'b1;
          flag_addr  = sel_tail;
          total_next = total_count - 1'b1;
        end
      end
      ACT_PREEMPT: begin
        r_preempt = preempt_q;
      end
      ACT_PEEK: begin
        if (sel_ok_q) begin
          r_thread = sel_head;
          r_found  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      flag_mem[clr_cnt] <= 1'b0;
    end else if (exec_fire && flag_we) begin
      flag_mem[flag_addr] <= flag_data;
    end
    if (exec_fire && link_we) begin
      next_mem[sel_tail] <= tid_q;
      prev_mem[tid_q]    <= sel_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && head_we) begin
      bucket_head[sel_b_q] <= head_next;
    end
    if (exec_fire && tail_we) begin
      bucket_tail[sel_b_q] <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        bucket_length[b] <= '0;
      end
      total_count <= '0;
    end else if (exec_fire) begin
      if (len_we) begin
        bucket_length[sel_b_q] <= len_next;
      end
      total_count <= total_next;
    end
  end

  // Response register
  logic [TID_W+THREAD_ID_W-1:0] r_thread_wide;
  logic [CNT_W+TOTAL_W-1:0]     total_wide;

  assign r_thread_wide = (TID_W + THREAD_ID_W)'(r_thread);
  assign total_wide    = (CNT_W + TOTAL_W)'(total_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result_thread <= r_thread_wide[THREAD_ID_W-1:0];
      found         <= r_found;
      status        <= r_status;
      preempt       <= r_preempt;
      queued_total  <= total_wide[TOTAL_W-1:0];
    end
  end

endmodule

`default_nettype wire
